// ----- hdl/frame_stamped_vertex_cache_assert.svh -----
// ----------------------------------------------------------------------------
// frame_stamped_vertex_cache_assert.svh
// assertion macros shared by the vertex cache rtl
// ----------------------------------------------------------------------------
`ifndef FRAME_STAMPED_VERTEX_CACHE_ASSERT_SVH
`define FRAME_STAMPED_VERTEX_CACHE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FSVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FSVC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fsvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvc_pkg
// shared types and constants of the frame stamped vertex cache
// ----------------------------------------------------------------------------
package fsvc_pkg;

    localparam int unsigned FRAME_W = 64;
    localparam int unsigned KEY_W   = 16;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned HASH_W  = 32;

    // hash multipliers
    localparam logic [HASH_W-1:0] HASH_MUL_X = 32'h85EB_CA77;
    localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'hC2B2_AE3D;

    // result status codes
    localparam logic [1:0] STATUS_INSERT   = 2'd0;
    localparam logic [1:0] STATUS_REUSE    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // one table entry as stored in the slot memory
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
        logic [KEY_W-1:0]   key_x;
        logic [KEY_W-1:0]   key_y;
        logic               precise;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
    } fsvc_entry_t;

    localparam int unsigned ENTRY_W = $bits(fsvc_entry_t);

endpackage

// ----- hdl/fsvc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvc_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fsvc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/fsvc_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvc_hash
// key hash and start slot: two registered multiplies, xor fold, then the
// remainder by the table size (mask, or a two-stage reciprocal multiply)
// ----------------------------------------------------------------------------
module fsvc_hash #(
    parameter int unsigned CAPACITY = 1024,
    localparam int unsigned IDX_W   = $clog2(CAPACITY)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic signed [15:0] key_x,
    input  logic signed [15:0] key_y,
    output logic              done,
    output logic [IDX_W-1:0]  slot
);

    import fsvc_pkg::*;

    localparam bit            POW2  = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam int unsigned   SH    = HASH_W + IDX_W;
    localparam int unsigned   RCP_W = HASH_W + 1;
    localparam int unsigned   PRD_W = HASH_W + RCP_W;
    // reciprocal of the table size rounded up; the quotient is exact for
    // every 32-bit hash when the size is not a power of two
    localparam logic [63:0]       RCP_FULL = ((64'd1 << SH) + 64'(CAPACITY) - 64'd1)
                                             / 64'(CAPACITY);
    localparam logic [RCP_W-1:0]  RCP      = RCP_W'(RCP_FULL);
    localparam logic [HASH_W-1:0] CAP_H    = HASH_W'(CAPACITY);

    logic [HASH_W-1:0] ext_x;
    logic [HASH_W-1:0] ext_y;
    logic [HASH_W-1:0] px_reg;
    logic [HASH_W-1:0] py_reg;
    logic              v1_reg;
    logic [HASH_W-1:0] mix;
    logic [HASH_W-1:0] h_reg;
    logic              v2_reg;
    logic [PRD_W-1:0]  prod_reg;
    logic [HASH_W-1:0] hq_reg;
    logic              v3_reg;
    logic [HASH_W-1:0] quo;
    logic [HASH_W-1:0] rem_full;
    logic [IDX_W-1:0]  rem_reg;
    logic              v4_reg;

    // stage one: sign extend and multiply, low 32 bits kept
    assign ext_x = {{(HASH_W - 16){key_x[15]}}, key_x};
    assign ext_y = {{(HASH_W - 16){key_y[15]}}, key_y};

    always_ff @(posedge clk)
    begin
        px_reg   <= HASH_W'(ext_x * HASH_MUL_X);
        py_reg   <= HASH_W'(ext_y * HASH_MUL_Y);
        h_reg    <= mix;
        prod_reg <= {{RCP_W{1'b0}}, h_reg} * {{HASH_W{1'b0}}, RCP};
        hq_reg   <= h_reg;
        rem_reg  <= IDX_W'(rem_full);
    end

    // stage two: xor and xor-shift fold
    always_comb
    begin
        mix = px_reg ^ py_reg;
        mix = mix ^ (mix >> 16);
    end

    // remainder from the quotient; quotient times size never exceeds the hash
    assign quo      = HASH_W'(prod_reg >> SH);
    assign rem_full = hq_reg - quo * CAP_H;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // power of two sizes take the low bits straight away
    assign done = POW2 ? v2_reg : v4_reg;
    assign slot = POW2 ? h_reg[IDX_W-1:0] : rem_reg;

endmodule

// ----- hdl/frame_stamped_vertex_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stamped_vertex_cache
// per-frame vertex position cache: open addressing hash table with linear
// probing, all slots held in one synchronous memory
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_stall  frame_number key_x key_y cand_precise cand_x cand_y
//  output   out_valid/out_stall  res_x res_y res_precise status
//
//  an item is hashed (accept plus two multiply/fold stages) and then probes one
//  slot at a time, bounded by the one-read-per-cycle memory port, until a slot
//  decides; at most CAPACITY slots are probed
//  a capacity that is not a power of two adds the reciprocal product and remainder registers
//  after reset a clearing pass writes every slot with input stalled; a finished
//  result waits in the output register, and only the next finishing item
//  waits on out_stall
// ----------------------------------------------------------------------------
`include "frame_stamped_vertex_cache_assert.svh"

module frame_stamped_vertex_cache #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        frame_number,
    input  logic signed [15:0] key_x,
    input  logic signed [15:0] key_y,
    input  logic               cand_precise,
    input  logic signed [31:0] cand_x,
    input  logic signed [31:0] cand_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic               res_precise,
    output logic [1:0]         status
);

    import fsvc_pkg::*;

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W:0]   CAP_W    = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] SLOT_MAX = IDX_W'(CAPACITY - 1);

    // controller state codes
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [IDX_W-1:0]   clr_reg;
    logic [IDX_W-1:0]   clr_next;
    logic [IDX_W-1:0]   slot_reg;
    logic [IDX_W-1:0]   slot_next;
    logic [IDX_W:0]     cnt_reg;
    logic [IDX_W:0]     cnt_next;

    logic [FRAME_W-1:0] frame_reg;
    logic [KEY_W-1:0]   kx_reg;
    logic [KEY_W-1:0]   ky_reg;
    logic               prec_reg;
    logic [POS_W-1:0]   cx_reg;
    logic [POS_W-1:0]   cy_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [POS_W-1:0]   res_x_reg;
    logic [POS_W-1:0]   res_x_next;
    logic [POS_W-1:0]   res_y_reg;
    logic [POS_W-1:0]   res_y_next;
    logic               res_prec_reg;
    logic               res_prec_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;

    logic               in_accept;
    logic               out_free;
    logic               hash_done;
    logic [IDX_W-1:0]   hash_slot;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    fsvc_entry_t        rd_entry;
    fsvc_entry_t        new_entry;
    logic               slot_free;
    logic               key_hit;
    logic               last_probe;
    logic [IDX_W-1:0]   slot_inc;
    logic [POS_W-1:0]   scaled_x;
    logic [POS_W-1:0]   scaled_y;

    logic               wr_legal;
    logic               res_quiet;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // start slot from the key
    fsvc_hash #(
        .CAPACITY (CAPACITY)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .key_x (key_x),
        .key_y (key_y),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    // slot memory
    fsvc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // probe decision on the slot read last cycle
    assign rd_entry   = fsvc_entry_t'(ram_rdata);
    assign slot_free  = !rd_entry.valid || (rd_entry.frame != frame_reg);
    assign key_hit    = (rd_entry.key_x == kx_reg) && (rd_entry.key_y == ky_reg);
    assign last_probe = (cnt_reg + 1'b1) == CAP_W;
    assign slot_inc   = (({1'b0, slot_reg} + 1'b1) == CAP_W) ? '0 : slot_reg + 1'b1;
    assign scaled_x   = {kx_reg, 16'h0000};
    assign scaled_y   = {ky_reg, 16'h0000};

    // entry written on insert
    always_comb
    begin
        new_entry.valid   = 1'b1;
        new_entry.frame   = frame_reg;
        new_entry.key_x   = kx_reg;
        new_entry.key_y   = ky_reg;
        new_entry.precise = prec_reg;
        new_entry.pos_x   = prec_reg ? cx_reg : scaled_x;
        new_entry.pos_y   = prec_reg ? cy_reg : scaled_y;
    end

    // controller
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = ENTRY_W'(new_entry);
        ram_raddr      = slot_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_prec_next  = res_prec_reg;
        status_next    = status_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == SLOT_MAX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    ram_raddr  = hash_slot;
                    slot_next  = hash_slot;
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                priority if (slot_free)
                begin
                    if (out_free)
                    begin
                        ram_we         = 1'b1;
                        out_valid_next = 1'b1;
                        res_x_next     = new_entry.pos_x;
                        res_y_next     = new_entry.pos_y;
                        res_prec_next  = prec_reg;
                        status_next    = STATUS_INSERT;
                        state_next     = ST_IDLE;
                    end
                end
                else if (key_hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        res_x_next     = rd_entry.pos_x;
                        res_y_next     = rd_entry.pos_y;
                        res_prec_next  = rd_entry.precise;
                        status_next    = STATUS_REUSE;
                        state_next     = ST_IDLE;
                    end
                end
                else if (last_probe)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        res_x_next     = scaled_x;
                        res_y_next     = scaled_y;
                        res_prec_next  = 1'b0;
                        status_next    = STATUS_OVERFLOW;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    ram_raddr = slot_inc;
                    slot_next = slot_inc;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            slot_reg      <= slot_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            frame_reg <= frame_number;
            kx_reg    <= key_x;
            ky_reg    <= key_y;
            prec_reg  <= cand_precise;
            cx_reg    <= cand_x;
            cy_reg    <= cand_y;
        end
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_prec_reg <= res_prec_next;
        status_reg   <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign res_x       = res_x_reg;
    assign res_y       = res_y_reg;
    assign res_precise = res_prec_reg;
    assign status      = status_reg;

    // check terms
    assign wr_legal  = (state_reg == ST_CLEAR) || (state_reg == ST_PROBE);
    assign res_quiet = !out_valid_reg && (state_reg != ST_PROBE);

    // checks
    `FSVC_ASSERT_NOW(a_probe_bound, state_reg == ST_PROBE, cnt_reg < CAP_W, "probe count overrun")
    `FSVC_ASSERT_NOW(a_write_state, ram_we, wr_legal, "slot write outside clear or probe")
    `FSVC_ASSERT_NOW(a_hash_state, hash_done, state_reg == ST_HASH, "stray hash result")
    `FSVC_ASSERT_NXT(a_result_src, res_quiet, !out_valid_reg, "result appeared without a probe")

endmodule

// ----- bench/frame_stamped_vertex_cache_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stamped_vertex_cache_tb
// drives vertex lookups into the frame stamped vertex cache and checks each
// canonical position and status against a software copy of the hash table;
// covers field extremes, stale frames, probe collisions and wrap, a full
// table with overflow, and mixed per-frame bursts under input and output
// idling
// ----------------------------------------------------------------------------
module frame_stamped_vertex_cache_tb;

    import fsvc_pkg::*;

    localparam int unsigned SLOTS        = 1024;
    // worst probe walk plus pipeline, used for the final drain
    localparam int unsigned DRAIN_CYCLES = SLOTS + 64;
    // slowest legal run is far below this: long probe walks only in the full-table
    // fill run and its overflow tail, everything else a handful of probes
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned MIXED_ITEMS  = 10;

    typedef enum int {PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} idle_phase_e;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic [KEY_W-1:0]   kx;
        logic [KEY_W-1:0]   ky;
        logic               precise;
        logic [POS_W-1:0]   cx;
        logic [POS_W-1:0]   cy;
        idle_phase_e        phase;
    } vertex_item_t;

    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             precise;
        logic [1:0]       status;
    } canon_res_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [63:0]        frame_number = '0;
    logic signed [15:0] key_x        = '0;
    logic signed [15:0] key_y        = '0;
    logic               cand_precise = 1'b0;
    logic signed [31:0] cand_x       = '0;
    logic signed [31:0] cand_y       = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic               res_precise;
    logic [1:0]         status;

    // software copy of the slot memory
    logic               mdl_valid   [SLOTS];
    logic [FRAME_W-1:0] mdl_frame   [SLOTS];
    logic [KEY_W-1:0]   mdl_kx      [SLOTS];
    logic [KEY_W-1:0]   mdl_ky      [SLOTS];
    logic               mdl_precise [SLOTS];
    logic [POS_W-1:0]   mdl_px      [SLOTS];
    logic [POS_W-1:0]   mdl_py      [SLOTS];

    vertex_item_t       lookup_q[$];
    canon_res_t         canon_q[$];
    vertex_item_t       drv_item;
    idle_phase_e        run_phase     = PH_STEADY;
    logic [FRAME_W-1:0] last_frame    = '0;
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count    = 0;

    frame_stamped_vertex_cache #(
        .CAPACITY(SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .frame_number(frame_number),
        .key_x(key_x),
        .key_y(key_y),
        .cand_precise(cand_precise),
        .cand_x(cand_x),
        .cand_y(cand_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .res_x(res_x),
        .res_y(res_y),
        .res_precise(res_precise),
        .status(status)
    );

    always #2 clk = ~clk;

    // start slot of a key: sign-extend, two multiplies, xor, xor-shift
    function automatic int unsigned home_slot(input logic [KEY_W-1:0] kx,
                                              input logic [KEY_W-1:0] ky);
        logic [HASH_W-1:0] ex;
        logic [HASH_W-1:0] ey;
        logic [HASH_W-1:0] h;
        ex = {{16{kx[15]}}, kx};
        ey = {{16{ky[15]}}, ky};
        h  = (ex * HASH_MUL_X) ^ (ey * HASH_MUL_Y);
        h  = h ^ (h >> 16);
        return h % SLOTS;
    endfunction

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // walk the table for one lookup and queue the canonical result
    task automatic resolve_vertex(input logic [FRAME_W-1:0] fr,
                                  input logic [KEY_W-1:0] kx,
                                  input logic [KEY_W-1:0] ky,
                                  input logic prec,
                                  input logic [POS_W-1:0] cx,
                                  input logic [POS_W-1:0] cy);
        int unsigned s;
        bit          done;
        canon_res_t  r;
        s    = home_slot(kx, ky);
        done = 1'b0;
        for (int unsigned n = 0; n < SLOTS && !done; n++)
        begin
            if (!mdl_valid[s] || mdl_frame[s] != fr)
            begin
                mdl_valid[s]   = 1'b1;
                mdl_frame[s]   = fr;
                mdl_kx[s]      = kx;
                mdl_ky[s]      = ky;
                mdl_precise[s] = prec;
                mdl_px[s]      = prec ? cx : {kx, 16'h0000};
                mdl_py[s]      = prec ? cy : {ky, 16'h0000};
                r = '{mdl_px[s], mdl_py[s], prec, STATUS_INSERT};
                done = 1'b1;
            end
            else if (mdl_kx[s] == kx && mdl_ky[s] == ky)
            begin
                r = '{mdl_px[s], mdl_py[s], mdl_precise[s], STATUS_REUSE};
                done = 1'b1;
            end
            else
                s = (s == SLOTS - 1) ? 0 : s + 1;
        end
        if (!done)
            r = '{{kx, 16'h0000}, {ky, 16'h0000}, 1'b0, STATUS_OVERFLOW};
        canon_q.push_back(r);
    endtask

    task automatic add_item(input logic [FRAME_W-1:0] fr, input logic [KEY_W-1:0] kx,
                            input logic [KEY_W-1:0] ky, input logic prec,
                            input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy,
                            input idle_phase_e ph);
        vertex_item_t it;
        it = '{fr, kx, ky, prec, cx, cy, ph};
        lookup_q.push_back(it);
    endtask

    task automatic add_rand_cand(input logic [FRAME_W-1:0] fr, input logic [KEY_W-1:0] kx,
                                 input logic [KEY_W-1:0] ky, input idle_phase_e ph);
        add_item(fr, kx, ky, 1'($urandom_range(0, 1)), $urandom, $urandom, ph);
    endtask

    // random search for a key whose probe starts at the given slot
    task automatic find_slot_key(input int unsigned target,
                                 output logic [KEY_W-1:0] kx, output logic [KEY_W-1:0] ky);
        kx = KEY_W'($urandom);
        ky = KEY_W'($urandom);
        while (home_slot(kx, ky) != target)
        begin
            kx = KEY_W'($urandom);
            ky = KEY_W'($urandom);
        end
    endtask

    function automatic logic [KEY_W-1:0] edge_key();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // one frame worth of lookups over a small key pool
    task automatic add_burst(input idle_phase_e ph, output int unsigned n_added);
        int unsigned        kind;
        int unsigned        nkeys;
        int unsigned        nitems;
        int unsigned        target;
        int unsigned        pick;
        logic [KEY_W-1:0]   pool_x[$];
        logic [KEY_W-1:0]   pool_y[$];
        logic [KEY_W-1:0]   kx;
        logic [KEY_W-1:0]   ky;
        logic [FRAME_W-1:0] fr;
        kind   = $urandom_range(0, 9);
        target = ($urandom_range(0, 3) == 0) ? SLOTS - 1 : $urandom_range(0, SLOTS - 1);
        if (kind == 9)
            fr = ($urandom_range(0, 1) == 0) ? {FRAME_W{1'b0}} : {FRAME_W{1'b1}};
        else if ($urandom_range(0, 2) == 0)
            fr = last_frame;
        else
            fr = {$urandom, $urandom};
        last_frame = fr;
        nkeys = (kind == 8) ? 1 : (kind >= 6 && kind <= 7) ? $urandom_range(2, 6)
                                                             : $urandom_range(1, 24);
        for (int unsigned i = 0; i < nkeys; i++)
        begin
            if (kind == 6 || kind == 7)
                find_slot_key(target, kx, ky);
            else if (kind == 9)
            begin
                kx = edge_key();
                ky = edge_key();
            end
            else
            begin
                kx = KEY_W'($urandom);
                ky = KEY_W'($urandom);
            end
            pool_x.push_back(kx);
            pool_y.push_back(ky);
        end
        nitems = (kind == 8) ? 1 : nkeys + $urandom_range(0, 2 * nkeys);
        for (int unsigned i = 0; i < nitems; i++)
        begin
            pick = (i < nkeys) ? i : $urandom_range(0, nkeys - 1);
            add_rand_cand(fr, pool_x[pick], pool_y[pick], ph);
        end
        n_added = nitems;
    endtask

    // directed cases: extremes, stale frames, collisions and wrap
    task automatic add_directed();
        logic [FRAME_W-1:0] ones;
        logic [FRAME_W-1:0] fr;
        logic [KEY_W-1:0]   wax, way, wbx, wby;
        logic [KEY_W-1:0]   cax, cay, cbx, cby, ccx, ccy;
        int unsigned        target;
        ones = {FRAME_W{1'b1}};
        add_item('0, 16'h0000, 16'h0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, PH_STEADY);
        add_item('0, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 32'h0000_0000, PH_STEADY);
        add_item('0, 16'h8000, 16'h7FFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PH_STEADY);
        add_item('0, 16'h7FFF, 16'h8000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, PH_STEADY);
        add_item('0, 16'hFFFF, 16'hFFFF, 1'b0, 32'h5555_AAAA, 32'hAAAA_5555, PH_STEADY);
        add_item('0, 16'h8000, 16'h7FFF, 1'b1, 32'h1234_5678, 32'h8765_4321, PH_STEADY);
        // same key under another frame stamp overwrites the stale slot
        add_item(ones, 16'h0000, 16'h0000, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, PH_STEADY);
        add_item(ones, 16'h0000, 16'h0000, 1'b1, 32'h0F0F_0F0F, 32'hF0F0_F0F0, PH_STEADY);
        add_item('0, 16'h0000, 16'h0000, 1'b1, 32'hDEAD_BEEF, 32'h0BAD_F00D, PH_STEADY);
        // two keys on the last slot, second one wraps to slot zero
        fr = {$urandom, $urandom};
        find_slot_key(SLOTS - 1, wax, way);
        find_slot_key(SLOTS - 1, wbx, wby);
        add_item(fr, wax, way, 1'b1, $urandom, $urandom, PH_STEADY);
        add_item(fr, wbx, wby, 1'b0, $urandom, $urandom, PH_STEADY);
        add_item(fr, wbx, wby, 1'b1, $urandom, $urandom, PH_STEADY);
        add_item(fr, wax, way, 1'b0, $urandom, $urandom, PH_STEADY);
        // three-deep collision chain
        target = $urandom_range(0, SLOTS - 2);
        find_slot_key(target, cax, cay);
        find_slot_key(target, cbx, cby);
        find_slot_key(target, ccx, ccy);
        add_item(fr, cax, cay, 1'b1, $urandom, $urandom, PH_STEADY);
        add_item(fr, cbx, cby, 1'b1, $urandom, $urandom, PH_STEADY);
        add_item(fr, ccx, ccy, 1'b0, $urandom, $urandom, PH_STEADY);
        add_item(fr, ccx, ccy, 1'b1, $urandom, $urandom, PH_STEADY);
    endtask

    // fill every slot within one frame, then overflow and deep reuse
    task automatic add_fill_run();
        logic [FRAME_W-1:0] fr;
        logic [KEY_W-1:0]   base;
        logic [KEY_W-1:0]   fill_kx[SLOTS];
        int unsigned        pick;
        fr   = {$urandom, $urandom};
        base = KEY_W'($urandom);
        for (int unsigned i = 0; i < SLOTS; i++)
        begin
            fill_kx[i] = KEY_W'($urandom);
            add_rand_cand(fr, fill_kx[i], base + KEY_W'(i), idle_phase_e'(i / 256));
        end
        for (int unsigned j = 0; j < 12; j++)
        begin
            pick = $urandom_range(0, SLOTS - 1);
            if (j % 2 == 0)
                add_rand_cand(fr, KEY_W'($urandom), base + KEY_W'(SLOTS + j), PH_BOTH);
            else
                add_rand_cand(fr, fill_kx[pick], base + KEY_W'(pick), PH_BOTH);
        end
        // next frame finds the whole table stale
        add_rand_cand(fr + 1, fill_kx[0], base, PH_BOTH);
    endtask

    task automatic check_result();
        canon_res_t want;
        if (canon_q.size() == 0)
        begin
            $error("result item with no lookup outstanding");
            mismatch_count++;
        end
        else
        begin
            want = canon_q.pop_front();
            if (res_x !== want.x)
            begin
                $error("res_x mismatch: expected %h, got %h", want.x, res_x);
                mismatch_count++;
            end
            if (res_y !== want.y)
            begin
                $error("res_y mismatch: expected %h, got %h", want.y, res_y);
                mismatch_count++;
            end
            if (res_precise !== want.precise)
            begin
                $error("res_precise mismatch: expected %b, got %b", want.precise,
                       res_precise);
                mismatch_count++;
            end
            if (status !== want.status)
            begin
                $error("status mismatch: expected %0d, got %0d", want.status, status);
                mismatch_count++;
            end
        end
    endtask

    // driver: present the next lookup once the bus is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                resolve_vertex(frame_number, key_x, key_y, cand_precise, cand_x, cand_y);
            if (!in_valid || !in_stall)
            begin
                if (lookup_q.size() != 0 &&
                    !((lookup_q[0].phase == PH_SRC_IDLE && roll(49)) ||
                      (lookup_q[0].phase == PH_BOTH && roll(36))))
                begin
                    drv_item = lookup_q.pop_front();
                    frame_number <= drv_item.frame;
                    key_x        <= drv_item.kx;
                    key_y        <= drv_item.ky;
                    cand_precise <= drv_item.precise;
                    cand_x       <= drv_item.cx;
                    cand_y       <= drv_item.cy;
                    run_phase    <= drv_item.phase;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= (run_phase == PH_SINK_STALL && roll(49)) ||
                         (run_phase == PH_BOTH && roll(36));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus build, reset, drain and verdict
    initial
    begin
        int unsigned added;
        int unsigned n;
        for (int unsigned i = 0; i < SLOTS; i++)
            mdl_valid[i] = 1'b0;
        add_directed();
        add_fill_run();
        for (int p = PH_STEADY; p <= PH_BOTH; p++)
        begin
            added = 0;
            while (added < MIXED_ITEMS)
            begin
                add_burst(idle_phase_e'(p), n);
                added += n;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (lookup_q.size() != 0 || in_valid || canon_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && canon_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
